FILE: design/pds_pkg.sv
`default_nettype none

package pds_pkg;

    localparam int DELTA_W       = 16;
    localparam int GAIN_W        = 13;
    localparam int WEIGHT_W      = 8;
    localparam int OUT_W         = 21;
    localparam int FLAG_W        = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 2 * DELTA_W;
    localparam int OUT_DATA_W    = ((2 * OUT_W + 7) / 8) * 8;
    localparam int FRAC_BITS_DEF = 8;
    localparam int SUM_W         = 31;
    localparam int EMA_SHIFT     = 8;

    localparam logic [GAIN_W-1:0]   GAIN_LO   = 13'd13;
    localparam logic [GAIN_W-1:0]   GAIN_HI   = 13'd5120;
    localparam logic [GAIN_W-1:0]   GAIN_RST  = 13'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_HI = 8'd230;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd3;

    typedef struct packed {
        logic                enable;
        logic [GAIN_W-1:0]   gain_x;
        logic [GAIN_W-1:0]   gain_y;
        logic [WEIGHT_W-1:0] weight;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic count;
        logic mult;
        logic update;
        logic go;
        logic clear;
    } lane_ctl_t;

endpackage

`default_nettype wire

FILE: design/pds_cfg.sv
`default_nettype none

module pds_cfg
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pds_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pds_pkg::cfg_t                         cfg,
    output logic                                  clear
);

    pds_pkg::cfg_t                      cfg_reg;
    logic                               wr;
    logic [pds_pkg::GAIN_W-1:0]         gain_raw;
    logic [pds_pkg::GAIN_W-1:0]         gain_clamped;
    logic [pds_pkg::WEIGHT_W-1:0]       weight_raw;
    logic [pds_pkg::WEIGHT_W-1:0]       weight_clamped;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign clear     = wr && (cfg_index == pds_pkg::REG_ENABLE) && !cfg_data[0];
    assign cfg       = cfg_reg;

    assign gain_raw   = cfg_data[pds_pkg::GAIN_W-1:0];
    assign weight_raw = cfg_data[pds_pkg::WEIGHT_W-1:0];

    always_comb
    begin
        priority if (gain_raw < pds_pkg::GAIN_LO)
        begin
            gain_clamped = pds_pkg::GAIN_LO;
        end
        else if (gain_raw > pds_pkg::GAIN_HI)
        begin
            gain_clamped = pds_pkg::GAIN_HI;
        end
        else
        begin
            gain_clamped = gain_raw;
        end
        weight_clamped = (weight_raw > pds_pkg::WEIGHT_HI) ? pds_pkg::WEIGHT_HI : weight_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable <= 1'b0;
            cfg_reg.gain_x <= pds_pkg::GAIN_RST;
            cfg_reg.gain_y <= pds_pkg::GAIN_RST;
            cfg_reg.weight <= '0;
        end
        else if (wr)
        begin
            unique case (cfg_index)
                pds_pkg::REG_ENABLE: cfg_reg.enable <= cfg_data[0];
                pds_pkg::REG_GAIN_X: cfg_reg.gain_x <= gain_clamped;
                pds_pkg::REG_GAIN_Y: cfg_reg.gain_y <= gain_clamped;
                pds_pkg::REG_WEIGHT: cfg_reg.weight <= weight_clamped;
                default:             cfg_reg      <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/pds_lane.sv
`default_nettype none

module pds_lane
#(
    parameter int FRAC_BITS = pds_pkg::FRAC_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire pds_pkg::lane_ctl_t                    ctl,
    input  wire logic signed [pds_pkg::DELTA_W-1:0]    delta,
    input  wire logic [pds_pkg::GAIN_W-1:0]            gain,
    input  wire logic [pds_pkg::WEIGHT_W-1:0]          weight,
    output logic signed [pds_pkg::OUT_W-1:0]           result
);

    localparam int OUT_W  = pds_pkg::OUT_W;
    localparam int SUM_W  = pds_pkg::SUM_W;
    localparam int WT_W   = pds_pkg::WEIGHT_W;
    localparam int SH     = pds_pkg::EMA_SHIFT;
    localparam int PROD_W = pds_pkg::DELTA_W + pds_pkg::GAIN_W + 1;
    localparam int REM_W  = FRAC_BITS + 1;
    localparam int CNT_W  = SUM_W - FRAC_BITS;
    localparam int EXT_W  = (CNT_W > OUT_W) ? CNT_W : OUT_W;
    localparam int SM_W   = OUT_W + FRAC_BITS;
    localparam int P1_W   = OUT_W + WT_W + 2;
    localparam int P2_W   = SM_W + WT_W + 1;
    localparam int T_W    = P1_W + FRAC_BITS + 1;
    localparam int Q_W    = T_W - SH;

    localparam logic signed [EXT_W-1:0] CNT_MAX = EXT_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [EXT_W-1:0] CNT_MIN = EXT_W'(-(2 ** (OUT_W - 1)));
    localparam logic signed [SM_W-1:0]  HALF    = SM_W'(2 ** (FRAC_BITS - 1));
    localparam logic [WT_W:0]           W_ONE   = (WT_W + 1)'(2 ** SH);

    logic signed [REM_W-1:0]  rem_reg;
    logic signed [SM_W-1:0]   sm_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [OUT_W-1:0]  cnt_reg;
    logic signed [P1_W-1:0]   p1_reg;
    logic signed [P2_W-1:0]   p2_reg;
    logic signed [SM_W-1:0]   s_reg;

    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum_next;
    logic [FRAC_BITS-1:0]     frac;
    logic                     neg_frac;
    logic signed [CNT_W-1:0]  quot;
    logic signed [EXT_W-1:0]  quot_ext;
    logic signed [OUT_W-1:0]  cnt_next;
    logic signed [REM_W-1:0]  rem_next;
    logic [WT_W:0]            inv_w;
    logic signed [P1_W-1:0]   p1_next;
    logic signed [P2_W-1:0]   p2_next;
    logic signed [T_W-1:0]    t_sum;
    logic                     t_adj;
    logic signed [Q_W-1:0]    t_quot;
    logic signed [SM_W-1:0]   s_raw;
    logic signed [SM_W-1:0]   s_next;
    logic                     s_adj;
    logic signed [OUT_W-1:0]  s_out;

    // load: delta times gain plus carried fraction
    assign prod     = delta * $signed({1'b0, gain});
    assign sum_next = SUM_W'(prod) + SUM_W'(rem_reg);

    // count: truncate toward zero, keep the fraction
    assign frac     = sum_reg[FRAC_BITS-1:0];
    assign neg_frac = sum_reg[SUM_W-1] && (frac != '0);
    assign quot     = sum_reg[SUM_W-1:FRAC_BITS] + CNT_W'(neg_frac);
    assign quot_ext = EXT_W'(quot);
    assign rem_next = {neg_frac, frac};

    always_comb
    begin
        priority if (quot_ext > CNT_MAX)
        begin
            cnt_next = OUT_W'(CNT_MAX);
        end
        else if (quot_ext < CNT_MIN)
        begin
            cnt_next = OUT_W'(CNT_MIN);
        end
        else
        begin
            cnt_next = OUT_W'(quot_ext);
        end
    end

    // mult: both ema partial products
    assign inv_w   = W_ONE - {1'b0, weight};
    assign p1_next = cnt_reg * $signed({1'b0, inv_w});
    assign p2_next = sm_reg * $signed({1'b0, weight});

    // update: blend, divide by 256 toward zero, snap small values
    assign t_sum  = (T_W'(p1_reg) <<< FRAC_BITS) + T_W'(p2_reg);
    assign t_adj  = t_sum[T_W-1] && (t_sum[SH-1:0] != '0);
    assign t_quot = t_sum[T_W-1:SH] + Q_W'(t_adj);
    assign s_raw  = SM_W'(t_quot);
    assign s_next = ((s_raw > -HALF) && (s_raw < HALF)) ? '0 : s_raw;

    assign s_adj  = s_reg[SM_W-1] && (s_reg[FRAC_BITS-1:0] != '0);
    assign s_out  = s_reg[SM_W-1:FRAC_BITS] + OUT_W'(s_adj);
    assign result = (weight != '0) ? s_out : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            sm_reg  <= '0;
        end
        else if (ctl.clear)
        begin
            rem_reg <= '0;
            sm_reg  <= '0;
        end
        else
        begin
            if (ctl.count && ctl.go)
            begin
                rem_reg <= rem_next;
            end
            if (ctl.update && ctl.go && (weight != '0))
            begin
                sm_reg <= s_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            sum_reg <= sum_next;
        end
        if (ctl.count)
        begin
            cnt_reg <= cnt_next;
        end
        if (ctl.mult)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (ctl.update)
        begin
            s_reg <= s_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/pointer_delta_scaler_top.sv
// pointer delta scaler: per-poll sensitivity scaling with fraction carry and smoothing
// s_t* channel takes one poll: tdata = delta_x, delta_y (signed 16 each);
// tuser = fetch_ok, is_pointer_poll, look_mode, right_held.
// m_t* channel gives one item per poll: tdata = out_x, out_y (signed 21 each),
// zero padded to 48 bits; tuser = applied.
// cfg_* writes registers: 0 enable, 1 gain_x, 2 gain_y, 3 smooth_weight.
// gains and weight are clamped on write; writing enable 0 clears the
// carried fractions and smoothed values of both axes.
// two identical lanes (x and y) run in parallel through four steps:
// multiply-add, truncate, ema products, blend; then the output register.
// a new poll is taken only once the last has moved to the output register;
// s_tready is high only while no poll is in flight.
// if m_tready is low, the finished result waits in the output register while
// the next poll may be taken; a second result waits in the lanes until the
// output register frees.
// reset: registers take their reset values (enable 0, gains 1.0, smoothing off),
// state is zero and both channels are empty.
`default_nettype none

module pointer_delta_scaler_top
#(
    parameter int FRAC_BITS = pds_pkg::FRAC_BITS_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [pds_pkg::IN_DATA_W-1:0]      s_tdata,   // delta_x, delta_y
    input  wire logic [pds_pkg::FLAG_W-1:0]         s_tuser,   // fetch_ok, is_pointer_poll,
                                                               // look_mode, right_held
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [pds_pkg::OUT_DATA_W-1:0]          m_tdata,   // out_x, out_y, zero pad
    output logic                                    m_tuser,   // applied
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pds_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DELTA_W = pds_pkg::DELTA_W;
    localparam int OUT_W   = pds_pkg::OUT_W;
    localparam int PAD_W   = pds_pkg::OUT_DATA_W - 2 * OUT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CNT  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    pds_pkg::cfg_t                    cfg;
    logic                             clear;
    pds_pkg::lane_ctl_t               ctl;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic                             go_reg;
    logic signed [DELTA_W-1:0]        dx_reg;
    logic signed [DELTA_W-1:0]        dy_reg;
    logic                             m_valid_reg;
    logic [pds_pkg::OUT_DATA_W-1:0]   m_data_reg;
    logic                             m_user_reg;

    logic                             accept;
    logic                             out_free;
    logic                             out_load;
    logic signed [DELTA_W-1:0]        in_dx;
    logic signed [DELTA_W-1:0]        in_dy;
    logic signed [OUT_W-1:0]          res_x;
    logic signed [OUT_W-1:0]          res_y;
    logic signed [OUT_W-1:0]          fin_x;
    logic signed [OUT_W-1:0]          fin_y;

    pds_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .clear     (clear)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = (state_reg == ST_FIN) && out_free;
    assign in_dx    = s_tdata[DELTA_W-1:0];
    assign in_dy    = s_tdata[2*DELTA_W-1:DELTA_W];

    assign ctl.load   = accept;
    assign ctl.count  = (state_reg == ST_CNT);
    assign ctl.mult   = (state_reg == ST_MUL);
    assign ctl.update = (state_reg == ST_UPD);
    assign ctl.go     = go_reg;
    assign ctl.clear  = clear;

    pds_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .delta  (in_dx),
        .gain   (cfg.gain_x),
        .weight (cfg.weight),
        .result (res_x)
    );

    pds_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .delta  (in_dy),
        .gain   (cfg.gain_y),
        .weight (cfg.weight),
        .result (res_y)
    );

    // merge: lane results or raw deltas on bypass
    assign fin_x = go_reg ? res_x : OUT_W'(dx_reg);
    assign fin_y = go_reg ? res_y : OUT_W'(dy_reg);

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = accept ? ST_CNT : ST_IDLE;
            ST_CNT:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_FIN;
            ST_FIN:  state_next = out_free ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            go_reg <= cfg.enable && (&s_tuser);
            dx_reg <= in_dx;
            dy_reg <= in_dy;
        end
        if (out_load)
        begin
            m_data_reg <= {{PAD_W{1'b0}}, fin_y, fin_x};
            m_user_reg <= go_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTH
    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && m_tvalid && !m_tready) |=> (state_reg == ST_FIN))
        else $error("finished result left the lanes while output was full");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CNT && !s_tready))
        else $error("accepted poll did not start the lane steps");

    a_bypass_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |->
        ((m_tdata[OUT_W-1:DELTA_W-1] == '0 || m_tdata[OUT_W-1:DELTA_W-1] == '1) &&
         (m_tdata[2*OUT_W-1:OUT_W+DELTA_W-1] == '0 ||
          m_tdata[2*OUT_W-1:OUT_W+DELTA_W-1] == '1)))
        else $error("bypassed item is not a raw 16 bit delta");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_FIN))
        else $error("output loaded outside the final step");
`endif

endmodule

`default_nettype wire
